// ----- rtl/eieu_pkg.sv -----
package eieu_pkg;

    typedef enum logic [4:0] {
        OP_SWAPNIB   = 5'd0,
        OP_MIRROR    = 5'd1,
        OP_TEST      = 5'd2,
        OP_BSLA      = 5'd3,
        OP_BSRA      = 5'd4,
        OP_BSRL      = 5'd5,
        OP_BSRF      = 5'd6,
        OP_BRLC      = 5'd7,
        OP_MUL       = 5'd8,
        OP_ADD_HL_A  = 5'd9,
        OP_ADD_DE_A  = 5'd10,
        OP_ADD_BC_A  = 5'd11,
        OP_ADD_HL_NN = 5'd12,
        OP_ADD_DE_NN = 5'd13,
        OP_ADD_BC_NN = 5'd14,
        OP_PUSH      = 5'd15,
        OP_OUTINB    = 5'd16,
        OP_NEXTREG_N = 5'd17,
        OP_NEXTREG_A = 5'd18,
        OP_PIXELDN   = 5'd19,
        OP_PIXELAD   = 5'd20,
        OP_SETAE     = 5'd21,
        OP_JP_C      = 5'd22,
        OP_LDIX      = 5'd23,
        OP_LDWS      = 5'd24,
        OP_LDDX      = 5'd25,
        OP_LDIRX     = 5'd26,
        OP_LDDRX     = 5'd27,
        OP_LDPIRX    = 5'd28,
        OP_LDIRSCALE = 5'd29,
        OP_LOOP      = 5'd30,
        OP_UNUSED    = 5'd31
    } op_t;

    typedef enum logic [1:0] {
        BUS_NONE = 2'd0,
        BUS_MEM  = 2'd1,
        BUS_PORT = 2'd2
    } bus_kind_t;

    localparam logic [15:0] NEXTREG_SEL_PORT = 16'h243B;
    localparam logic [15:0] NEXTREG_DAT_PORT = 16'h253B;

    localparam int FLAG_C = 0;
    localparam int FLAG_N = 1;
    localparam int FLAG_P = 2;
    localparam int FLAG_X = 3;
    localparam int FLAG_H = 4;
    localparam int FLAG_Y = 5;
    localparam int FLAG_Z = 6;
    localparam int FLAG_S = 7;

    typedef struct packed {
        logic        last;
        logic [1:0]  bus_kind;
        logic [15:0] bus_addr;
        logic [7:0]  bus_data;
        logic [7:0]  new_a;
        logic [7:0]  new_f;
        logic [15:0] new_bc;
        logic [15:0] new_de;
        logic [15:0] new_hl;
        logic [15:0] new_pc;
        logic [15:0] new_sp;
        logic [4:0]  tstates;
    } result_t;

endpackage

// ----- rtl/eieu_alu.sv -----
module eieu_alu
    import eieu_pkg::*;
(
    input  logic [4:0]  op,
    input  logic [7:0]  reg_a,
    input  logic [7:0]  reg_f,
    input  logic [15:0] reg_bc,
    input  logic [15:0] reg_de,
    input  logic [15:0] reg_hl,
    input  logic [15:0] reg_pc,
    input  logic [15:0] reg_sp,
    input  logic [7:0]  operand_first,
    input  logic [7:0]  operand_second,
    input  logic [7:0]  source_byte,
    input  logic [7:0]  port_byte,
    output logic        two,
    output result_t     res_first,
    output result_t     res_final
);

    logic [4:0]  sh;
    logic [3:0]  rot;
    logic [31:0] ext_de;
    logic [31:0] ext_shr;
    logic [31:0] rot_dbl;
    logic [7:0]  and_v;
    logic [16:0] sum_a;
    logic [15:0] nn;
    logic [15:0] bc_dec;
    logic [7:0]  cp_sum;
    logic [7:0]  ws_d;
    logic [2:0]  mid;
    logic [7:0]  ph;
    logic [7:0]  pl;
    logic [7:0]  mir;
    result_t     fin;
    result_t     pre;

    always_comb
    begin
        sh      = reg_bc[12:8];
        rot     = reg_bc[11:8];
        and_v   = reg_a & operand_first;
        nn      = {operand_second, operand_first};
        bc_dec  = reg_bc - 16'd1;
        cp_sum  = source_byte + reg_a;
        ws_d    = reg_de[15:8] + 8'd1;
        mid     = reg_hl[7:5] + 3'd1;
        ext_de  = {{16{reg_de[15]}}, reg_de};
        ext_shr = $signed(ext_de) >>> sh;
        rot_dbl = {reg_de, reg_de} << rot;
        sum_a   = 17'(reg_a);
        ph      = '0;
        pl      = '0;
        for (int i = 0; i < 8; i++)
        begin
            mir[7 - i] = reg_a[i];
        end

        fin          = '0;
        fin.last     = 1'b1;
        fin.new_a    = reg_a;
        fin.new_f    = reg_f;
        fin.new_bc   = reg_bc;
        fin.new_de   = reg_de;
        fin.new_hl   = reg_hl;
        fin.new_pc   = reg_pc;
        fin.new_sp   = reg_sp;
        fin.tstates  = 5'd8;
        pre          = '0;
        two          = 1'b0;

        case (op)
            OP_SWAPNIB: fin.new_a = {reg_a[3:0], reg_a[7:4]};
            OP_MIRROR:  fin.new_a = mir;
            OP_TEST:
            begin
                fin.new_f         = '0;
                fin.new_f[FLAG_H] = 1'b1;
                fin.new_f[FLAG_S] = and_v[7];
                fin.new_f[FLAG_Z] = (and_v == 8'd0);
                fin.new_f[FLAG_P] = ~^and_v;
                fin.new_f[FLAG_X] = and_v[3];
                fin.new_f[FLAG_Y] = and_v[5];
                fin.new_pc        = reg_pc + 16'd1;
                fin.tstates       = 5'd11;
            end
            OP_BSLA: fin.new_de = (sh[4]) ? 16'd0 : reg_de << sh[3:0];
            OP_BSRA: fin.new_de = ext_shr[15:0];
            OP_BSRL: fin.new_de = (sh[4]) ? 16'd0 : reg_de >> sh[3:0];
            OP_BSRF: fin.new_de = ~((~reg_de) >> sh);
            OP_BRLC: fin.new_de = rot_dbl[31:16];
            OP_MUL:  fin.new_de = reg_de[15:8] * reg_de[7:0];
            OP_ADD_HL_A:
            begin
                sum_a           = {1'b0, reg_hl} + sum_a;
                fin.new_hl      = sum_a[15:0];
                fin.new_f[FLAG_C] = sum_a[16];
            end
            OP_ADD_DE_A:
            begin
                sum_a           = {1'b0, reg_de} + sum_a;
                fin.new_de      = sum_a[15:0];
                fin.new_f[FLAG_C] = sum_a[16];
            end
            OP_ADD_BC_A:
            begin
                sum_a           = {1'b0, reg_bc} + sum_a;
                fin.new_bc      = sum_a[15:0];
                fin.new_f[FLAG_C] = sum_a[16];
            end
            OP_ADD_HL_NN, OP_ADD_DE_NN, OP_ADD_BC_NN:
            begin
                if (op == OP_ADD_HL_NN) fin.new_hl = reg_hl + nn;
                else if (op == OP_ADD_DE_NN) fin.new_de = reg_de + nn;
                else fin.new_bc = reg_bc + nn;
                fin.new_pc  = reg_pc + 16'd2;
                fin.tstates = 5'd16;
            end
            OP_PUSH:
            begin
                two          = 1'b1;
                pre.bus_kind = BUS_MEM;
                pre.bus_addr = reg_sp - 16'd1;
                pre.bus_data = operand_first;
                fin.bus_kind = BUS_MEM;
                fin.bus_addr = reg_sp - 16'd2;
                fin.bus_data = operand_second;
                fin.new_sp   = reg_sp - 16'd2;
                fin.new_pc   = reg_pc + 16'd2;
                fin.tstates  = 5'd23;
            end
            OP_OUTINB:
            begin
                fin.bus_kind = BUS_PORT;
                fin.bus_addr = reg_bc;
                fin.bus_data = source_byte;
                fin.new_hl   = reg_hl + 16'd1;
                fin.tstates  = 5'd16;
            end
            OP_NEXTREG_N, OP_NEXTREG_A:
            begin
                two          = 1'b1;
                pre.bus_kind = BUS_PORT;
                pre.bus_addr = NEXTREG_SEL_PORT;
                pre.bus_data = operand_first;
                fin.bus_kind = BUS_PORT;
                fin.bus_addr = NEXTREG_DAT_PORT;
                if (op == OP_NEXTREG_N)
                begin
                    fin.bus_data = operand_second;
                    fin.new_pc   = reg_pc + 16'd2;
                    fin.tstates  = 5'd20;
                end
                else
                begin
                    fin.bus_data = reg_a;
                    fin.new_pc   = reg_pc + 16'd1;
                    fin.tstates  = 5'd17;
                end
            end
            OP_PIXELDN:
            begin
                if (reg_hl[10:8] != 3'd7)
                    fin.new_hl = {reg_hl[15:8] + 8'd1, reg_hl[7:0]};
                else
                begin
                    ph = {reg_hl[15:11], 3'd0};
                    if (mid == 3'd0) ph = ph + 8'h08;
                    fin.new_hl = {ph, mid, reg_hl[4:0]};
                end
            end
            OP_PIXELAD:
            begin
                ph = {3'b010, reg_de[15:14], reg_de[10:8]};
                pl = {reg_de[13:11], reg_de[7:3]};
                fin.new_hl = {ph, pl};
            end
            OP_SETAE:  fin.new_a = 8'h80 >> reg_de[2:0];
            OP_JP_C:
            begin
                fin.new_pc  = {reg_pc[15:14], port_byte, 6'd0};
                fin.tstates = 5'd13;
            end
            OP_LDIX, OP_LDDX, OP_LDIRX, OP_LDDRX, OP_LDIRSCALE, OP_LDPIRX:
            begin
                if (source_byte != reg_a)
                begin
                    fin.bus_kind = BUS_MEM;
                    fin.bus_addr = reg_de;
                    fin.bus_data = source_byte;
                end
                fin.new_de = reg_de + 16'd1;
                fin.new_bc = bc_dec;
                if (op != OP_LDPIRX)
                begin
                    fin.new_hl = (op == OP_LDDX || op == OP_LDDRX) ?
                                 reg_hl - 16'd1 : reg_hl + 16'd1;
                    fin.new_f  = '0;
                    fin.new_f[FLAG_C] = reg_f[FLAG_C];
                    fin.new_f[FLAG_Z] = reg_f[FLAG_Z];
                    fin.new_f[FLAG_S] = reg_f[FLAG_S];
                    fin.new_f[FLAG_P] = (bc_dec != 16'd0);
                    fin.new_f[FLAG_X] = cp_sum[3];
                    fin.new_f[FLAG_Y] = cp_sum[1];
                end
                fin.tstates = 5'd16;
                if (op >= OP_LDIRX && bc_dec != 16'd0)
                begin
                    fin.new_pc  = reg_pc - 16'd2;
                    fin.tstates = 5'd21;
                end
            end
            OP_LDWS:
            begin
                fin.bus_kind = BUS_MEM;
                fin.bus_addr = reg_de;
                fin.bus_data = source_byte;
                fin.new_hl   = {reg_hl[15:8], reg_hl[7:0] + 8'd1};
                fin.new_f    = '0;
                fin.new_f[FLAG_C] = reg_f[FLAG_C];
                fin.new_f[FLAG_Z] = (ws_d == 8'd0);
                fin.new_f[FLAG_S] = ws_d[7];
                fin.new_f[FLAG_X] = ws_d[3];
                fin.new_f[FLAG_Y] = ws_d[5];
                fin.new_f[FLAG_P] = (ws_d == 8'h80);
                fin.new_f[FLAG_H] = (ws_d[3:0] == 4'd0);
                fin.new_de   = {ws_d, reg_de[7:0]};
                fin.tstates  = 5'd14;
            end
            default: ;
        endcase

        res_first = pre;
        res_final = fin;
    end

endmodule

// ----- rtl/extended_instruction_execute_unit.sv -----
// Extended instruction execute unit. Takes one instruction per clock with all
// operands present, while out_ready is high and no second write is pending,
// and returns its bus writes in order, the last result carrying the new
// registers and T-states. Single-write and no-write ops give one result in the
// cycle after the transfer in; push and nextreg give two results and hold off
// the input until the second result has moved from the pending register into
// the result register. The decode and the 8x8 multiply sit between the input
// port and the result register.
module extended_instruction_execute_unit
    import eieu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  op,
    input  logic [7:0]  reg_a,
    input  logic [7:0]  reg_f,
    input  logic [15:0] reg_bc,
    input  logic [15:0] reg_de,
    input  logic [15:0] reg_hl,
    input  logic [15:0] reg_pc,
    input  logic [15:0] reg_sp,
    input  logic [7:0]  operand_first,
    input  logic [7:0]  operand_second,
    input  logic [7:0]  source_byte,
    input  logic [7:0]  port_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        last,
    output logic [1:0]  bus_kind,
    output logic [15:0] bus_addr,
    output logic [7:0]  bus_data,
    output logic [7:0]  new_a,
    output logic [7:0]  new_f,
    output logic [15:0] new_bc,
    output logic [15:0] new_de,
    output logic [15:0] new_hl,
    output logic [15:0] new_pc,
    output logic [15:0] new_sp,
    output logic [4:0]  tstates
);

    logic    two;
    result_t res_first;
    result_t res_final;
    result_t out_reg;
    result_t pend_reg;
    logic    out_valid_reg;
    logic    pend_valid_reg;
    logic    out_free;

    eieu_alu u_alu (
        .op             (op),
        .reg_a          (reg_a),
        .reg_f          (reg_f),
        .reg_bc         (reg_bc),
        .reg_de         (reg_de),
        .reg_hl         (reg_hl),
        .reg_pc         (reg_pc),
        .reg_sp         (reg_sp),
        .operand_first  (operand_first),
        .operand_second (operand_second),
        .source_byte    (source_byte),
        .port_byte      (port_byte),
        .two            (two),
        .res_first      (res_first),
        .res_final      (res_final)
    );

    // output register frees when empty or taken this cycle
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = out_free && !pend_valid_reg;

    // valid flags for result register and second-write stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg  <= in_valid;
                pend_valid_reg <= in_valid && two;
            end
        end
    end

    // result payloads
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (pend_valid_reg)
                out_reg <= pend_reg;
            else if (in_valid)
            begin
                out_reg  <= two ? res_first : res_final;
                pend_reg <= res_final;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign last      = out_reg.last;
    assign bus_kind  = out_reg.bus_kind;
    assign bus_addr  = out_reg.bus_addr;
    assign bus_data  = out_reg.bus_data;
    assign new_a     = out_reg.new_a;
    assign new_f     = out_reg.new_f;
    assign new_bc    = out_reg.new_bc;
    assign new_de    = out_reg.new_de;
    assign new_hl    = out_reg.new_hl;
    assign new_pc    = out_reg.new_pc;
    assign new_sp    = out_reg.new_sp;
    assign tstates   = out_reg.tstates;

endmodule

// ----- rtl/eieu_checker.sv -----
module eieu_checker
    import eieu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       last,
    input  logic [1:0] bus_kind,
    input  logic [4:0] tstates
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(last))
        else $error("result dropped while stalled");

    // a non-final result always carries a bus write
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> bus_kind != BUS_NONE)
        else $error("non-final result without write");

    // final result carries a sane t-state count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> tstates >= 5'd8)
        else $error("bad t-states");

    // a non-final transfer is followed by its final result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && last)
        else $error("second write missing");

    // an input transfer always shows a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("result missing after input transfer");

endmodule

bind extended_instruction_execute_unit eieu_checker u_eieu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .last      (last),
    .bus_kind  (bus_kind),
    .tstates   (tstates)
);
